// File: hw/rtl/dcs_pkg.sv
`default_nettype none

package dcs_pkg;

  localparam int CMD_W = 3;
  localparam int CH_W  = 9;
  localparam int LV_W  = 8;
  localparam int ST_W  = 2;
  localparam int CFG_W = 10;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [LV_W-1:0]  level_t;
  typedef logic [ST_W-1:0]  status_t;
  typedef logic [CFG_W-1:0] count_t;

  // command codes
  localparam cmd_t CMD_WRITE     = 3'd0;
  localparam cmd_t CMD_SET       = 3'd1;
  localparam cmd_t CMD_READ      = 3'd2;
  localparam cmd_t CMD_SCAN      = 3'd3;
  localparam cmd_t CMD_CLR_MARKS = 3'd4;
  localparam cmd_t CMD_CLR_ALL   = 3'd5;

  // status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_NONE  = 2'd2;

  localparam level_t MARK_ALL  = 8'hFF;
  localparam count_t CFG_RESET = 10'd512;

endpackage

`default_nettype wire

// File: hw/rtl/dcs_ram.sv
`default_nettype none

module dcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dmx_channel_store_with_change_marks_core.sv
`default_nettype none
// write, set, read: accepted into S_RMW, then the result register; busy drops as the
//   result appears, so the next beat can be taken in that cycle
// out of range or unknown command: busy stays low; out of range gives a result in the next cycle
// change scan: one ram read per channel, stopping early at MSG_CAPACITY hits
// clear commands: MAX_CHANNELS entries, one per cycle on the ram write port
// reset: busy for a clearing pass over both stores; results are never held off

module dmx_channel_store_with_change_marks_core #(
  parameter int MAX_CHANNELS = 512,
  parameter int MSG_CAPACITY = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // command side
  input  wire logic             start,
  output logic                  busy,
  input  wire dcs_pkg::cmd_t    cmd,
  input  wire dcs_pkg::chan_t   channel_index,
  input  wire dcs_pkg::level_t  level_in,
  // configuration
  input  wire logic             cfg_write,
  input  wire dcs_pkg::count_t  cfg_data,
  // results
  output logic                  result_valid,
  output dcs_pkg::status_t      status,
  output dcs_pkg::chan_t        channel_out,
  output dcs_pkg::level_t       level_out,
  output dcs_pkg::level_t       change_bits,
  output logic                  last
);

  import dcs_pkg::*;

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int HW = $clog2(MSG_CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RMW   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0] state;

  // config register and effective channel count
  count_t channels_in_use;
  count_t n_act;

  // rmw operand
  cmd_t   op_cmd;
  chan_t  op_ch;
  level_t op_level;

  // scan walker: issue index, read-data tag, held hit
  count_t         iss_idx;
  logic           d_valid;
  chan_t          d_idx;
  logic           held_valid;
  chan_t          held_ch;
  level_t         held_level;
  level_t         held_mark;
  logic [HW-1:0]  hit_cnt;
  chan_t          scan_start;

  // clear sweep
  logic [AW-1:0] clr_idx;
  logic          clr_all;
  logic          clr_cmd;

  // result register
  logic    res_valid;
  status_t res_status;
  chan_t   res_channel;
  level_t  res_level;
  level_t  res_mark;
  logic    res_last;

  // ram ports
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  level_t        rd_level;
  level_t        rd_mark;
  logic [AW-1:0] wr_addr;
  logic          level_we;
  level_t        level_wdata;
  logic          mark_we;
  level_t        mark_wdata;

  logic in_range;
  logic iss_more;
  logic scan_rd;
  logic hit;
  logic cap_hit;
  logic is_rmw_cmd;

  assign n_act = (channels_in_use > CFG_W'(MAX_CHANNELS)) ? CFG_W'(MAX_CHANNELS)
                                                           : channels_in_use;
  assign in_range   = {1'b0, channel_index} < n_act;
  assign is_rmw_cmd = (cmd == CMD_WRITE) || (cmd == CMD_SET) || (cmd == CMD_READ);

  // scan issues one read per cycle while channels remain
  assign iss_more = iss_idx < n_act;
  assign scan_rd  = (state == S_SCAN) && iss_more;
  assign hit      = d_valid && (rd_mark != '0);
  assign cap_hit  = hit_cnt == HW'(MSG_CAPACITY - 1);

  // read port: addressed straight from the command in idle so data is ready next cycle
  assign rd_en   = ((state == S_IDLE) && start && is_rmw_cmd && in_range) || scan_rd;
  assign rd_addr = (state == S_IDLE) ? channel_index[AW-1:0] : iss_idx[AW-1:0];

  // write port: rmw write-back or clear sweep
  always_comb begin
    wr_addr     = op_ch[AW-1:0];
    level_we    = 1'b0;
    level_wdata = op_level;
    mark_we     = 1'b0;
    mark_wdata  = (op_cmd == CMD_SET) ? MARK_ALL : (rd_mark | (rd_level ^ op_level));
    case (state)
      S_RMW: begin
        level_we = op_cmd != CMD_READ;
        mark_we  = op_cmd != CMD_READ;
      end
      S_CLEAR: begin
        wr_addr     = clr_idx;
        level_we    = clr_all;
        level_wdata = '0;
        mark_we     = 1'b1;
        mark_wdata  = '0;
      end
      default: begin
      end
    endcase
  end

  dcs_ram #(.WIDTH(LV_W), .DEPTH(MAX_CHANNELS)) u_level_ram (
    .clk   (clk),
    .we    (level_we),
    .waddr (wr_addr),
    .wdata (level_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_level)
  );

  dcs_ram #(.WIDTH(LV_W), .DEPTH(MAX_CHANNELS)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (wr_addr),
    .wdata (mark_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_mark)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // reset starts a clearing pass over both stores
      state           <= S_CLEAR;
      clr_idx         <= '0;
      clr_all         <= 1'b1;
      clr_cmd         <= 1'b0;
      res_valid       <= 1'b0;
      d_valid         <= 1'b0;
      held_valid      <= 1'b0;
      hit_cnt         <= '0;
      channels_in_use <= CFG_RESET;
    end else begin
      res_valid <= 1'b0;
      d_valid   <= scan_rd;
      d_idx     <= iss_idx[CH_W-1:0];
      if (cfg_write) begin
        channels_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd)
              CMD_WRITE, CMD_SET, CMD_READ, CMD_SCAN: begin
                if (!in_range) begin
                  // out of range: nothing stored, flagged right away
                  res_valid   <= 1'b1;
                  res_status  <= ST_RANGE;
                  res_channel <= channel_index;
                  res_level   <= '0;
                  res_mark    <= '0;
                  res_last    <= 1'b1;
                end else if (cmd == CMD_SCAN) begin
                  iss_idx    <= {1'b0, channel_index};
                  scan_start <= channel_index;
                  held_valid <= 1'b0;
                  hit_cnt    <= '0;
                  state      <= S_SCAN;
                end else begin
                  op_cmd   <= cmd;
                  op_ch    <= channel_index;
                  op_level <= level_in;
                  state    <= S_RMW;
                end
              end
              CMD_CLR_MARKS, CMD_CLR_ALL: begin
                clr_idx <= '0;
                clr_all <= cmd == CMD_CLR_ALL;
                clr_cmd <= 1'b1;
                state   <= S_CLEAR;
              end
              default: begin
                // unknown command: dropped without a result
              end
            endcase
          end
        end
        S_RMW: begin
          // ram data for op_ch is valid now; write back and report new contents
          res_valid   <= 1'b1;
          res_status  <= ST_OK;
          res_channel <= op_ch;
          res_level   <= (op_cmd == CMD_READ) ? rd_level : op_level;
          res_mark    <= (op_cmd == CMD_READ) ? rd_mark : mark_wdata;
          res_last    <= 1'b1;
          state       <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_rd) begin
            iss_idx <= iss_idx + 1'b1;
          end
          if (hit) begin
            // previous hit goes out now; it is known not to be the final one
            if (held_valid) begin
              res_valid   <= 1'b1;
              res_status  <= ST_OK;
              res_channel <= held_ch;
              res_level   <= held_level;
              res_mark    <= held_mark;
              res_last    <= 1'b0;
            end
            held_valid <= 1'b1;
            held_ch    <= d_idx;
            held_level <= rd_level;
            held_mark  <= rd_mark;
            hit_cnt    <= hit_cnt + 1'b1;
            if (cap_hit) begin
              state <= S_FIN;
            end
          end else if (!iss_more && !d_valid) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_valid <= 1'b1;
          res_last  <= 1'b1;
          if (held_valid) begin
            res_status  <= ST_OK;
            res_channel <= held_ch;
            res_level   <= held_level;
            res_mark    <= held_mark;
          end else begin
            res_status  <= ST_NONE;
            res_channel <= scan_start;
            res_level   <= '0;
            res_mark    <= '0;
          end
          state <= S_IDLE;
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(MAX_CHANNELS - 1)) begin
            state <= S_IDLE;
            if (clr_cmd) begin
              res_valid   <= 1'b1;
              res_status  <= ST_OK;
              res_channel <= '0;
              res_level   <= '0;
              res_mark    <= '0;
              res_last    <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = state != S_IDLE;
  assign result_valid = res_valid;
  assign status       = res_status;
  assign channel_out  = res_channel;
  assign level_out    = res_level;
  assign change_bits  = res_mark;
  assign last         = res_last;

  // reset always begins the clearing pass
  a_reset_clears: assert property (@(posedge clk) rst |=> busy)
    else $error("reset did not start clearing pass");

  // failure results carry no store contents and end the item
  a_fail_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_RANGE || status == ST_NONE)
      |-> last && level_out == '0 && change_bits == '0)
    else $error("failure result with payload or not last");

  // only scan hits come out before the final beat, and each one is marked
  a_mid_scan_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == ST_OK && change_bits != '0)
    else $error("non-final beat is not a changed channel");

  // the scan never runs past the message capacity
  a_scan_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> hit_cnt < HW'(MSG_CAPACITY))
    else $error("scan exceeded message capacity");

endmodule

`default_nettype wire
